>>> hdl/bvtu_pkg.sv
package bvtu_pkg;

  localparam int NUM_ARMS   = 16;
  localparam int ARM_W      = 4;
  localparam int IDX_W      = $clog2(NUM_ARMS);
  localparam int DATA_W     = 32;
  localparam int CODE_SHIFT = 26;
  localparam int CODE_W     = DATA_W - CODE_SHIFT;
  localparam int MUL_STEPS  = DATA_W;
  localparam int STEP_W     = $clog2(MUL_STEPS);
  localparam int CFG_IDX_W  = 2;

  localparam logic [ARM_W:0]  ARM_LIMIT = (ARM_W + 1)'(NUM_ARMS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MUL_STEPS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_RATE   = 2'd0,
    CFG_PRIOR_VALUE = 2'd1,
    CFG_RATE_DECAY  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic start;
    logic step;
  } mul_ctl_t;

  typedef struct packed {
    logic              en;
    logic              load_all;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] value;
    logic [DATA_W-1:0] rate;
  } tbl_wr_t;

endpackage

>>> hdl/bandit_value_table_update_core.sv
// Channel  Ports                                        Direction
// in       in_valid in_stall in_func in_arm in_reward   word in
// out      out_valid out_stall out_arm_echo out_new_value
//          out_synapse_code out_new_rate                word out
// cfg      cfg_we cfg_index cfg_wdata                   write only
// An update word passes from acceptance through ST_READ, which reads the arm,
// ST_MUL, which runs the two bit-serial multipliers, and ST_DONE, which loads the output register.
// A table load word or an arm out of range skips ST_MUL.
// Reset is synchronous; it empties the table to zero defaults and clears the control and config registers.
// A result waiting under out_stall does not block acceptance of the next word.
module bandit_value_table_update_core
  import bvtu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_func,
  input  logic [ARM_W-1:0]     in_arm,
  input  logic                 in_reward,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ARM_W-1:0]     out_arm_echo,
  output logic [DATA_W-1:0]    out_new_value,
  output logic [CODE_W-1:0]    out_synapse_code,
  output logic [DATA_W-1:0]    out_new_rate,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata
);

  state_t state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DATA_W-1:0] base_rate_r, prior_value_r, rate_decay_r;
  logic [ARM_W-1:0]  arm_r;
  logic              reward_r, load_r, oor_r;
  logic [DATA_W-1:0] val_r, rate_r;
  logic              out_valid_r;
  logic [ARM_W-1:0]  out_arm_r;
  logic [DATA_W-1:0] out_value_r, out_rate_r;

  logic              accept, commit, out_free, in_range;
  logic [DATA_W-1:0] rd_value, rd_rate, prod_value, prod_rate;
  logic [DATA_W-1:0] upd_value, upd_rate, res_value, res_rate;
  logic [ARM_W-1:0]  res_arm;
  mul_ctl_t          mul_ctl;
  tbl_wr_t           tbl_wr;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign in_range = {1'b0, in_arm} < ARM_LIMIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_rate_r   <= '0;
      prior_value_r <= '0;
      rate_decay_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BASE_RATE:   base_rate_r   <= cfg_wdata;
        CFG_PRIOR_VALUE: prior_value_r <= cfg_wdata;
        CFG_RATE_DECAY:  rate_decay_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  bvtu_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_idx   (IDX_W'(in_arm)),
    .rd_value (rd_value),
    .rd_rate  (rd_rate),
    .wr       (tbl_wr)
  );

  // The value multiplier is the low 32 bits of 2^32 - rate; a zero rate is patched below.
  bvtu_serial_mul u_mul_value (
    .clk  (clk),
    .ctl  (mul_ctl),
    .a    (rd_value),
    .b    ('0 - rd_rate),
    .p_hi (prod_value)
  );

  bvtu_serial_mul u_mul_rate (
    .clk  (clk),
    .ctl  (mul_ctl),
    .a    (rd_rate),
    .b    (rate_decay_r),
    .p_hi (prod_rate)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (accept) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = (load_r || oor_r) ? ST_DONE : ST_MUL;
      end
      ST_MUL: begin
        cnt_nxt = cnt_r + STEP_W'(1);
        if (cnt_r == LAST_STEP) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    mul_ctl.start = 1'b0;
    mul_ctl.step  = 1'b0;
    commit        = 1'b0;
    unique case (state_r)
      ST_IDLE: in_stall = 1'b0;
      ST_READ: mul_ctl.start = 1'b1;
      ST_MUL:  mul_ctl.step = 1'b1;
      ST_DONE: commit = out_free;
      default: ;
    endcase
  end

  always_comb begin
    upd_value = (rate_r == '0) ? val_r : prod_value;
    if (reward_r) begin
      upd_value = upd_value + rate_r;
    end
    upd_rate = (rate_decay_r != '0) ? prod_rate : rate_r;
    priority if (load_r) begin
      res_arm   = '0;
      res_value = prior_value_r;
      res_rate  = base_rate_r;
    end else if (oor_r) begin
      res_arm   = arm_r;
      res_value = '0;
      res_rate  = '0;
    end else begin
      res_arm   = arm_r;
      res_value = upd_value;
      res_rate  = upd_rate;
    end
    tbl_wr.en       = commit && !load_r && !oor_r;
    tbl_wr.load_all = commit && load_r;
    tbl_wr.idx      = IDX_W'(arm_r);
    tbl_wr.value    = res_value;
    tbl_wr.rate     = res_rate;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      arm_r    <= in_arm;
      reward_r <= in_reward;
      load_r   <= in_func;
      oor_r    <= !in_func && !in_range;
    end
    if (mul_ctl.start) begin
      val_r  <= rd_value;
      rate_r <= rd_rate;
    end
    if (commit) begin
      out_arm_r   <= res_arm;
      out_value_r <= res_value;
      out_rate_r  <= res_rate;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_arm_echo     = out_arm_r;
  assign out_new_value    = out_value_r;
  assign out_synapse_code = out_value_r[DATA_W-1:CODE_SHIFT];
  assign out_new_rate     = out_rate_r;

`ifndef SYNTH
  a_update_enters_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_func && in_range) |=> (state_r == ST_READ) ##1 (state_r == ST_MUL))
    else $error("accepted update did not start the multipliers");

  a_mul_runs_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && cnt_r != LAST_STEP) |=> (state_r == ST_MUL))
    else $error("multiply sequence ended early");

  a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid && out_stall) |=> (state_r == ST_DONE))
    else $error("result dropped while output register was full");

  a_code_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_synapse_code == out_new_value[DATA_W-1:CODE_SHIFT]))
    else $error("synapse code does not match new value");
`endif

endmodule

>>> hdl/bvtu_serial_mul.sv
module bvtu_serial_mul
  import bvtu_pkg::*;
(
  input  logic              clk,
  input  mul_ctl_t          ctl,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic [DATA_W-1:0] p_hi
);

  logic [DATA_W-1:0] a_r;
  logic [DATA_W-1:0] b_r;
  logic [DATA_W-1:0] acc_r;
  logic [DATA_W:0]   sum;

  // One multiplier bit per cycle while ctl.step is high, least significant first; the low half falls off.
  assign sum  = {1'b0, acc_r} + (b_r[0] ? {1'b0, a_r} : {(DATA_W + 1){1'b0}});
  assign p_hi = acc_r;

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (ctl.step) begin
      acc_r <= sum[DATA_W:1];
      b_r   <= {1'b0, b_r[DATA_W-1:1]};
    end
  end

endmodule

>>> hdl/bvtu_table.sv
module bvtu_table
  import bvtu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [IDX_W-1:0]  rd_idx,
  output logic [DATA_W-1:0] rd_value,
  output logic [DATA_W-1:0] rd_rate,
  input  tbl_wr_t           wr
);

  logic [DATA_W-1:0] value_mem_r [NUM_ARMS];
  logic [DATA_W-1:0] rate_mem_r  [NUM_ARMS];
  logic [NUM_ARMS-1:0] loaded_r;
  logic [DATA_W-1:0] snap_value_r;
  logic [DATA_W-1:0] snap_rate_r;
  logic [DATA_W-1:0] value_q_r;
  logic [DATA_W-1:0] rate_q_r;
  logic              loaded_q_r;

  // An arm not written since the last table load reads as the loaded defaults.
  assign rd_value = loaded_q_r ? value_q_r : snap_value_r;
  assign rd_rate  = loaded_q_r ? rate_q_r  : snap_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r     <= '0;
      snap_value_r <= '0;
      snap_rate_r  <= '0;
    end else if (wr.load_all) begin
      loaded_r     <= '0;
      snap_value_r <= wr.value;
      snap_rate_r  <= wr.rate;
    end else if (wr.en) begin
      loaded_r[wr.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      value_mem_r[wr.idx] <= wr.value;
      rate_mem_r[wr.idx]  <= wr.rate;
    end
    value_q_r  <= value_mem_r[rd_idx];
    rate_q_r   <= rate_mem_r[rd_idx];
    loaded_q_r <= loaded_r[rd_idx];
  end

endmodule
